[design/eye_anim_pkg.sv]
// ----------------------------------------------------------------------------
// eye_anim_pkg: shared types and constants of the eye animation renderer
// Geometry of the two eyes, animation constants, and the transfer payloads.
// ----------------------------------------------------------------------------
package eye_anim_pkg;

    localparam int DISPLAY_WIDTH = 128;
    localparam int DISPLAY_PAGES = 8;
    localparam int LANES         = 8;

    localparam int EYE_CENTER_Y  = 32;
    localparam int LEFT_CX       = 32;
    localparam int RIGHT_CX      = 96;
    localparam int LEFT_X_LO     = 6;
    localparam int LEFT_X_HI     = 60;
    localparam int RIGHT_X_LO    = 68;
    localparam int RIGHT_X_HI    = 122;
    localparam int EYE_RADIUS_X  = 26;
    localparam int LID_OPEN      = 26;
    localparam int LID_BLINK     = 3;

    localparam int RX_SQ         = EYE_RADIUS_X * EYE_RADIUS_X;
    localparam int LID_OPEN_SQ   = LID_OPEN * LID_OPEN;
    localparam int LID_BLINK_SQ  = LID_BLINK * LID_BLINK;
    localparam int ELL_OPEN_LIM  = RX_SQ * LID_OPEN_SQ;
    localparam int ELL_BLINK_LIM = RX_SQ * LID_BLINK_SQ;

    localparam int BLINK_RESET_LIMIT = 99;
    localparam int BLINK_BASE    = 40;
    localparam int BLINK_END     = 1;
    localparam int PHASE_MOD     = 36;
    localparam int PHASE_STEP    = 12;
    localparam int RADIUS_BASE   = 7;
    localparam int GAZE_X_MAX    = 13;
    localparam int GAZE_X_BIAS   = 7;
    localparam int GAZE_Y_BIAS   = 4;
    localparam int BROW_DROP     = 4;
    localparam int SLEEPY_ROW    = 6;

    localparam int REG_EMOTION   = 0;

    typedef enum logic [1:0] {
        EMO_NORMAL = 2'd0,
        EMO_MAD    = 2'd1,
        EMO_SAD    = 2'd2,
        EMO_SLEEPY = 2'd3
    } emotion_t;

    typedef enum logic [1:0] {
        CTL_IDLE,
        CTL_SQUARE,
        CTL_FINISH
    } ctl_state_t;

    typedef enum logic {
        OP_FRAME  = 1'b0,
        OP_RENDER = 1'b1
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [6:0] column;
        logic [2:0] page;
        logic [6:0] blink_draw;
        logic       gaze_change;
        logic [3:0] gaze_x_draw;
        logic [2:0] gaze_y_draw;
    } in_item_t;

    typedef struct packed {
        logic [7:0] pixel_byte;
        logic       lid_closed;
    } out_item_t;

    // Animation state that the pixel lanes need for the current frame.
    typedef struct packed {
        logic              lid_blink;
        logic [3:0]        radius;
        logic signed [3:0] pupil_x;
        logic signed [2:0] pupil_y;
    } anim_state_t;

    typedef struct packed {
        emotion_t    emotion;
        anim_state_t anim;
    } lane_ctrl_t;

endpackage

[design/eye_anim_frame.sv]
// ----------------------------------------------------------------------------
// eye_anim_frame: animation state of the eyes
// Blink timer, lid height, pulse phase and pupil easing, one step per frame.
// ----------------------------------------------------------------------------
module eye_anim_frame (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      advance,
    input  eye_anim_pkg::in_item_t    item,
    output eye_anim_pkg::anim_state_t anim
);

    logic [7:0]        count_reg, count_next;
    logic [7:0]        limit_reg, limit_next;
    logic              active_reg, active_next;
    logic [4:0]        lid_reg, lid_next;
    logic [5:0]        phase_reg, phase_next;
    logic signed [3:0] pupil_x_reg, pupil_x_next;
    logic signed [2:0] pupil_y_reg, pupil_y_next;
    logic signed [3:0] target_x_reg, target_x_next;
    logic signed [2:0] target_y_reg, target_y_next;

    logic [7:0] cnt_inc;
    logic [7:0] cnt_mid;
    logic       start;
    logic       active_mid;
    logic       finish;
    logic [3:0] gx;

    always_comb
    begin
        phase_next = (phase_reg == 6'(eye_anim_pkg::PHASE_MOD - 1)) ? 6'd0
                                                                    : phase_reg + 6'd1;

        cnt_inc    = (count_reg != 8'hFF) ? count_reg + 8'd1 : count_reg;
        start      = !active_reg && (cnt_inc > limit_reg);
        active_mid = active_reg || start;
        cnt_mid    = start ? 8'd0 : cnt_inc;
        finish     = active_mid && (cnt_mid > 8'(eye_anim_pkg::BLINK_END));

        active_next = active_mid && !finish;
        count_next  = finish ? 8'd0 : cnt_mid;
        limit_next  = finish ? 8'(eye_anim_pkg::BLINK_BASE) + {1'b0, item.blink_draw}
                             : limit_reg;
        lid_next    = active_mid ? 5'(eye_anim_pkg::LID_BLINK) : 5'(eye_anim_pkg::LID_OPEN);

        // Draws above the range clamp to the rightmost target.
        gx = (item.gaze_x_draw > 4'(eye_anim_pkg::GAZE_X_MAX))
             ? 4'(eye_anim_pkg::GAZE_X_MAX) : item.gaze_x_draw;
        if (item.gaze_change)
        begin
            target_x_next = $signed(gx - 4'(eye_anim_pkg::GAZE_X_BIAS));
            target_y_next = $signed(item.gaze_y_draw - 3'(eye_anim_pkg::GAZE_Y_BIAS));
        end
        else
        begin
            target_x_next = target_x_reg;
            target_y_next = target_y_reg;
        end

        priority if (pupil_x_reg < target_x_next)
            pupil_x_next = pupil_x_reg + 4'sd1;
        else if (pupil_x_reg > target_x_next)
            pupil_x_next = pupil_x_reg - 4'sd1;
        else
            pupil_x_next = pupil_x_reg;

        priority if (pupil_y_reg < target_y_next)
            pupil_y_next = pupil_y_reg + 3'sd1;
        else if (pupil_y_reg > target_y_next)
            pupil_y_next = pupil_y_reg - 3'sd1;
        else
            pupil_y_next = pupil_y_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= 8'd0;
            limit_reg    <= 8'(eye_anim_pkg::BLINK_RESET_LIMIT);
            active_reg   <= 1'b0;
            lid_reg      <= 5'(eye_anim_pkg::LID_OPEN);
            phase_reg    <= 6'd0;
            pupil_x_reg  <= 4'sd0;
            pupil_y_reg  <= 3'sd0;
            target_x_reg <= 4'sd0;
            target_y_reg <= 3'sd0;
        end
        else if (advance)
        begin
            count_reg    <= count_next;
            limit_reg    <= limit_next;
            active_reg   <= active_next;
            lid_reg      <= lid_next;
            phase_reg    <= phase_next;
            pupil_x_reg  <= pupil_x_next;
            pupil_y_reg  <= pupil_y_next;
            target_x_reg <= target_x_next;
            target_y_reg <= target_y_next;
        end
    end

    // Pupil radius steps up by one per twelve pulse-phase frames, then wraps.
    always_comb
    begin
        anim.lid_blink = (lid_reg == 5'(eye_anim_pkg::LID_BLINK));
        priority if (phase_reg >= 6'(2 * eye_anim_pkg::PHASE_STEP))
            anim.radius = 4'(eye_anim_pkg::RADIUS_BASE + 2);
        else if (phase_reg >= 6'(eye_anim_pkg::PHASE_STEP))
            anim.radius = 4'(eye_anim_pkg::RADIUS_BASE + 1);
        else
            anim.radius = 4'(eye_anim_pkg::RADIUS_BASE);
        anim.pupil_x = pupil_x_reg;
        anim.pupil_y = pupil_y_reg;
    end

endmodule

[design/eye_anim_lane.sv]
// ----------------------------------------------------------------------------
// eye_anim_lane: one pixel of a page byte
// Squares the offsets in a first registered step, then tests the eye
// ellipse and the pupil circle and applies the emotion mask.
// ----------------------------------------------------------------------------
module eye_anim_lane (
    input  logic                     clk,
    input  logic                     en,
    input  logic [6:0]               column,
    input  logic [5:0]               row,
    input  eye_anim_pkg::lane_ctrl_t ctrl,
    output logic                     lit
);

    logic              left;
    logic              in_eye;
    logic [7:0]        cx;
    logic signed [7:0] dx;
    logic signed [6:0] dy;
    logic signed [7:0] dy8;
    logic signed [7:0] px;
    logic signed [7:0] py;
    logic [15:0]       dx_sq_full;
    logic [15:0]       dy_sq_full;
    logic [15:0]       px_sq_full;
    logic [15:0]       py_sq_full;
    logic signed [7:0] brow_v;
    logic signed [7:0] brow_adj;
    logic signed [7:0] brow_thr;
    logic              mask;

    logic        in_eye_reg;
    logic        mask_reg;
    logic [9:0]  dx2_reg;
    logic [10:0] dy2_reg;
    logic [11:0] dist_reg;

    logic [9:0]  ry_sq;
    logic [20:0] ell_lhs;
    logic [20:0] ell_lim;
    logic [7:0]  r_sq;

    always_comb
    begin
        left   = (column >= 7'(eye_anim_pkg::LEFT_X_LO)) &&
                 (column < 7'(eye_anim_pkg::LEFT_X_HI));
        in_eye = left || ((column >= 7'(eye_anim_pkg::RIGHT_X_LO)) &&
                          (column < 7'(eye_anim_pkg::RIGHT_X_HI)));
        cx     = left ? 8'(eye_anim_pkg::LEFT_CX) : 8'(eye_anim_pkg::RIGHT_CX);
        dx     = $signed({1'b0, column}) - $signed(cx);
        dy     = $signed({1'b0, row}) - $signed(7'(eye_anim_pkg::EYE_CENTER_Y));
        dy8    = {dy[6], dy};
        px     = dx - {{4{ctrl.anim.pupil_x[3]}}, ctrl.anim.pupil_x};
        py     = dy8 - {{5{ctrl.anim.pupil_y[2]}}, ctrl.anim.pupil_y};

        dx_sq_full = dx * dx;
        dy_sq_full = dy8 * dy8;
        px_sq_full = px * px;
        py_sq_full = py * py;

        // Brow slope: half of the signed column offset, truncated toward zero.
        brow_v   = (left == (ctrl.emotion == eye_anim_pkg::EMO_MAD)) ? dx : -dx;
        brow_adj = brow_v + $signed({7'd0, brow_v[7]});
        brow_thr = (brow_adj >>> 1) - 8'(eye_anim_pkg::BROW_DROP);

        unique case (ctrl.emotion)
            eye_anim_pkg::EMO_MAD,
            eye_anim_pkg::EMO_SAD:    mask = dy8 < brow_thr;
            eye_anim_pkg::EMO_SLEEPY: mask = dy8 < $signed(8'(eye_anim_pkg::SLEEPY_ROW));
            default:                  mask = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            in_eye_reg <= in_eye;
            mask_reg   <= mask;
            dx2_reg    <= dx_sq_full[9:0];
            dy2_reg    <= dy_sq_full[10:0];
            dist_reg   <= {1'b0, px_sq_full[10:0]} + {1'b0, py_sq_full[10:0]};
        end
    end

    always_comb
    begin
        ry_sq   = ctrl.anim.lid_blink ? 10'(eye_anim_pkg::LID_BLINK_SQ)
                                      : 10'(eye_anim_pkg::LID_OPEN_SQ);
        ell_lim = ctrl.anim.lid_blink ? 21'(eye_anim_pkg::ELL_BLINK_LIM)
                                      : 21'(eye_anim_pkg::ELL_OPEN_LIM);
        ell_lhs = 21'(dx2_reg * ry_sq) + 21'(dy2_reg * 10'(eye_anim_pkg::RX_SQ));
        r_sq    = 8'(ctrl.anim.radius * ctrl.anim.radius);
        lit     = in_eye_reg && (ell_lhs <= ell_lim) &&
                  (dist_reg > {4'd0, r_sq}) && !mask_reg;
    end

endmodule

[design/eye_animation_renderer_unit.sv]
// An accepted item is registered, the pixel lanes register their squared offsets, and the
// result is loaded into the output register once that register is free; no new item
// is accepted until then.
// The next item is taken while a finished result still waits in the output register.
// Reset (rst_n, asynchronous): emotion normal, lid open, blink limit 99, pupil centered.
// ----------------------------------------------------------------------------
// eye_animation_renderer_unit: two animated eyes on a one-bit page display
// Frame items advance the animation and return a zero byte; render items return one
// page byte from eight pixel lanes merged into the output register.
// ----------------------------------------------------------------------------
module eye_animation_renderer_unit (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  eye_anim_pkg::in_item_t  in_data,
    output logic                    out_valid,
    input  logic                    out_stall,
    output eye_anim_pkg::out_item_t out_data,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [2:0]              paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    eye_anim_pkg::ctl_state_t state_reg, state_next;
    eye_anim_pkg::emotion_t   emotion_reg;
    eye_anim_pkg::in_item_t   item_reg;
    eye_anim_pkg::out_item_t  out_data_reg;
    logic                     out_valid_reg, out_valid_next;

    eye_anim_pkg::anim_state_t anim;
    eye_anim_pkg::lane_ctrl_t  ctrl;
    logic                      accept;
    logic                      lane_en;
    logic                      load_out;
    logic [eye_anim_pkg::LANES-1:0] lane_bits;

    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == 1'(eye_anim_pkg::REG_EMOTION)) ? {30'd0, emotion_reg}
                                                                   : 32'd0;
    assign in_stall = (state_reg != eye_anim_pkg::CTL_IDLE);
    assign accept   = in_valid && !in_stall;
    assign ctrl     = '{emotion: emotion_reg, anim: anim};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            emotion_reg <= eye_anim_pkg::EMO_NORMAL;
        else if (psel && penable && pwrite && paddr[2] == 1'(eye_anim_pkg::REG_EMOTION))
            emotion_reg <= eye_anim_pkg::emotion_t'(pwdata[1:0]);
    end

    eye_anim_frame u_frame (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (accept && in_data.op == eye_anim_pkg::OP_FRAME),
        .item    (in_data),
        .anim    (anim)
    );

    for (genvar k = 0; k < eye_anim_pkg::LANES; k++)
    begin : g_lane
        eye_anim_lane u_lane (
            .clk    (clk),
            .en     (lane_en),
            .column (item_reg.column),
            .row    ({item_reg.page, 3'(k)}),
            .ctrl   (ctrl),
            .lit    (lane_bits[k])
        );
    end

    always_comb
    begin
        state_next     = state_reg;
        lane_en        = 1'b0;
        load_out       = 1'b0;
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            eye_anim_pkg::CTL_IDLE:
            begin
                if (accept)
                    state_next = eye_anim_pkg::CTL_SQUARE;
            end
            eye_anim_pkg::CTL_SQUARE:
            begin
                lane_en    = 1'b1;
                state_next = eye_anim_pkg::CTL_FINISH;
            end
            eye_anim_pkg::CTL_FINISH:
            begin
                // The result waits here until the output register is free.
                if (!out_valid_reg || !out_stall)
                begin
                    load_out       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = eye_anim_pkg::CTL_IDLE;
                end
            end
            default:
                state_next = eye_anim_pkg::CTL_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= eye_anim_pkg::CTL_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            item_reg <= in_data;
        if (load_out)
        begin
            out_data_reg.pixel_byte <= (item_reg.op == eye_anim_pkg::OP_RENDER) ? lane_bits
                                                                                 : 8'd0;
            out_data_reg.lid_closed <= anim.lid_blink;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
